FILE: sv/cwmm_pkg.sv
// shared constants and types for the cursor window statistics block
package cwmm_pkg;

   // store geometry
   localparam int STORE_DEPTH   = 4096;
   localparam int SAMPLE_BITS   = 16;
   localparam int ADDR_BITS     = $clog2(STORE_DEPTH);
   localparam int COUNT_BITS    = $clog2(STORE_DEPTH + 1);
   localparam int NUM_CHANNELS  = 2;
   localparam int CHAN_BITS     = 1;
   localparam int RAM_DEPTH     = NUM_CHANNELS * STORE_DEPTH;
   localparam int RAM_ADDR_BITS = CHAN_BITS + ADDR_BITS;

   // word field widths
   localparam int REQ_TYPE_BITS = 2;
   localparam int SAMPLE_IN_BITS = 16;
   localparam int CURSOR_BITS   = 13;
   localparam int SPAN_BITS     = 12;
   localparam int RESULT_BITS   = 16;

   // window sum and divider
   localparam int SUM_BITS      = SAMPLE_BITS + ADDR_BITS;
   localparam int DIV_STEP_BITS = $clog2(SUM_BITS + 1);

   // configuration registers
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_START_CURRENT = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_START_VOLTAGE = 1'b1;
   localparam logic [SAMPLE_BITS-1:0] MIN_START_CURRENT_RESET = SAMPLE_BITS'(10000);
   localparam logic [SAMPLE_BITS-1:0] MIN_START_VOLTAGE_RESET = SAMPLE_BITS'(7500);

   // request codes
   typedef enum logic [REQ_TYPE_BITS-1:0] {
      REQ_APPEND  = 2'd0,
      REQ_MEASURE = 2'd1,
      REQ_CLEAR   = 2'd2
   } req_code_type;

   // channel codes
   localparam logic [CHAN_BITS-1:0] CHAN_CURRENT = 1'b0;
   localparam logic [CHAN_BITS-1:0] CHAN_VOLTAGE = 1'b1;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DIVGO,
      ST_DIV,
      ST_DONE
   } state_type;

   // divider status back to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

FILE: sv/cwmm_req_if.sv
// request channel: valid/ready handshake with the request word
interface cwmm_req_if import cwmm_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [REQ_TYPE_BITS-1:0]  req_type;
   logic [CHAN_BITS-1:0]      channel;
   logic [SAMPLE_IN_BITS-1:0] sample_value;
   logic [CURSOR_BITS-1:0]    cursor_one;
   logic [CURSOR_BITS-1:0]    cursor_two;

   modport source (output valid, req_type, channel, sample_value, cursor_one, cursor_two,
                   input ready);
   modport sink   (input valid, req_type, channel, sample_value, cursor_one, cursor_two,
                   output ready);
endinterface

// response channel: valid/ready handshake with the measurement word
interface cwmm_rsp_if import cwmm_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   status;
   logic [SPAN_BITS-1:0]   span;
   logic [RESULT_BITS-1:0] mean_value;
   logic [RESULT_BITS-1:0] peak_max;
   logic [RESULT_BITS-1:0] peak_min;

   modport source (output valid, status, span, mean_value, peak_max, peak_min,
                   input ready);
   modport sink   (input valid, status, span, mean_value, peak_max, peak_min,
                   output ready);
endinterface

FILE: sv/cwmm_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module cwmm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/cwmm_div.sv
// restoring divider, one quotient bit per cycle, for the window mean
module cwmm_div import cwmm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [SUM_BITS-1:0]  dividend,
   input  logic [SPAN_BITS-1:0] divisor,
   output div_stat_type         stat,
   output logic [SUM_BITS-1:0]  quotient
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIV_STEP_BITS-1:0] step_ff, step_in;
   logic [SPAN_BITS-1:0]     den_ff, den_in;
   logic [SPAN_BITS-1:0]     rem_ff, rem_in;
   logic [SUM_BITS-1:0]      quo_ff, quo_in;
   logic [SPAN_BITS:0]       trial;

   // one shift-compare-subtract step
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff, quo_ff[SUM_BITS-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = DIV_STEP_BITS'(SUM_BITS);
         den_in  = divisor;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = SPAN_BITS'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[SUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[SPAN_BITS-1:0];
            quo_in = {quo_ff[SUM_BITS-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == DIV_STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

FILE: sv/cursor_window_mean_min_max.sv
// top level: two sample stores with cursor window mean, maximum and minimum
//
// Request words arrive on req_port (valid/ready). An append word writes its
// sample at the end of the selected store (current or voltage) and is
// dropped once the store holds 4096 samples; a clear word empties the store.
// Both give no response word. A measure word checks that
// both cursors lie in 1..count; if not, the sequencer goes straight to its
// done state for a response with status 1 and zero fields. Otherwise the
// window from the lower cursor up to, not including, the upper cursor is read
// from the store ram one sample per cycle, then a one-bit-per-cycle divider
// forms the mean. For span N the scan reads N samples (equal cursors count
// as one sample read) over the single ram read port before the 28-step divider.
// One request is handled at a time; req_port.ready is high while idle.
// The response word sits in an output register, so a new request is taken
// while an earlier response still waits; a stalled rsp_port holds the next
// measurement back until the register frees up.
// csr_* writes the two starting-minimum registers (index 0 current,
// index 1 voltage). Synchronous reset empties both stores and restores the
// starting minimums to 10000 mA and 7500 mV; no clearing pass is needed.
module cursor_window_mean_min_max import cwmm_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   cwmm_req_if.sink                  req_port,
   cwmm_rsp_if.source                rsp_port,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wr_data
);

   state_type              state_ff, state_in;
   logic [COUNT_BITS-1:0]  count_ff [NUM_CHANNELS];
   logic [COUNT_BITS-1:0]  count_in [NUM_CHANNELS];
   logic [SAMPLE_BITS-1:0] min_cur_ff, min_volt_ff;
   logic [CHAN_BITS-1:0]   ch_ff, ch_in;
   logic [ADDR_BITS-1:0]   addr_ff, addr_in;
   logic [COUNT_BITS-1:0]  left_ff, left_in;
   logic [SPAN_BITS-1:0]   span_ff, span_in;
   logic                   eq_ff, eq_in;
   logic                   err_ff, err_in;
   logic                   rd_pend_ff, rd_pend_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0] max_ff, max_in;
   logic [SAMPLE_BITS-1:0] min_ff, min_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_status_ff, rsp_status_in;
   logic [SPAN_BITS-1:0]   rsp_span_ff, rsp_span_in;
   logic [RESULT_BITS-1:0] rsp_mean_ff, rsp_mean_in;
   logic [RESULT_BITS-1:0] rsp_max_ff, rsp_max_in;
   logic [RESULT_BITS-1:0] rsp_min_ff, rsp_min_in;

   logic                     req_fire, rsp_fire;
   logic [COUNT_BITS-1:0]    req_count;
   logic                     range_ok;
   logic [CURSOR_BITS-1:0]   cur_lo, cur_hi, cur_diff;
   logic                     ram_wr_en, ram_rd_en;
   logic [RAM_ADDR_BITS-1:0] ram_wr_addr, ram_rd_addr;
   logic [SAMPLE_BITS-1:0]   ram_wr_data, ram_rd_data;
   logic                     div_start;
   logic [SPAN_BITS-1:0]     div_den;
   div_stat_type             div_stat;
   logic [SUM_BITS-1:0]      div_quo;

   assign req_fire = req_port.valid && req_port.ready;
   assign rsp_fire = rsp_valid_ff && rsp_port.ready;
   assign req_port.ready = (state_ff == ST_IDLE);

   // cursor checks against the selected store's fill count
   assign req_count = count_ff[req_port.channel];
   assign range_ok  = (req_port.cursor_one != '0) && (req_port.cursor_one <= req_count) &&
                      (req_port.cursor_two != '0) && (req_port.cursor_two <= req_count);
   assign cur_lo    = (req_port.cursor_one < req_port.cursor_two) ? req_port.cursor_one
                                                                   : req_port.cursor_two;
   assign cur_hi    = (req_port.cursor_one < req_port.cursor_two) ? req_port.cursor_two
                                                                   : req_port.cursor_one;
   assign cur_diff  = cur_hi - cur_lo;

   // store ram, channel selects the upper half
   assign ram_wr_addr = {req_port.channel, req_count[ADDR_BITS-1:0]};
   assign ram_wr_data = SAMPLE_BITS'(req_port.sample_value);
   assign ram_rd_addr = {ch_ff, addr_ff};

   cwmm_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // mean divider; equal cursors divide the single sample by one
   assign div_den = eq_ff ? SPAN_BITS'(1) : span_ff;

   cwmm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (div_den),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   // sequencer: next state and datapath updates
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ch_in         = ch_ff;
      addr_in       = addr_ff;
      left_in       = left_ff;
      span_in       = span_ff;
      eq_in         = eq_ff;
      err_in        = err_ff;
      sum_in        = sum_ff;
      max_in        = max_ff;
      min_in        = min_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_span_in   = rsp_span_ff;
      rsp_mean_in   = rsp_mean_ff;
      rsp_max_in    = rsp_max_ff;
      rsp_min_in    = rsp_min_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      div_start     = 1'b0;
      rd_pend_in    = (state_ff == ST_SCAN);

      // fold in the sample read last cycle
      if (rd_pend_ff) begin
         sum_in = sum_ff + SUM_BITS'(ram_rd_data);
         if (ram_rd_data > max_ff) begin
            max_in = ram_rd_data;
         end
         if (ram_rd_data < min_ff) begin
            min_in = ram_rd_data;
         end
      end

      // response register frees up when taken
      if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_port.req_type)
                  REQ_APPEND: begin
                     if (req_count < COUNT_BITS'(STORE_DEPTH)) begin
                        ram_wr_en = 1'b1;
                        count_in[req_port.channel] = req_count + 1'b1;
                     end
                  end
                  REQ_CLEAR: begin
                     count_in[req_port.channel] = '0;
                  end
                  REQ_MEASURE: begin
                     ch_in = req_port.channel;
                     if (!range_ok) begin
                        err_in   = 1'b1;
                        state_in = ST_DONE;
                     end else begin
                        err_in  = 1'b0;
                        eq_in   = (cur_diff == '0);
                        span_in = cur_diff[SPAN_BITS-1:0];
                        addr_in = ADDR_BITS'(cur_lo - 1'b1);
                        left_in = (cur_diff == '0) ? COUNT_BITS'(1) : COUNT_BITS'(cur_diff);
                        sum_in  = '0;
                        max_in  = '0;
                        if (cur_diff == '0) begin
                           min_in = '1;
                        end else if (req_port.channel == CHAN_VOLTAGE) begin
                           min_in = min_volt_ff;
                        end else begin
                           min_in = min_cur_ff;
                        end
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            ram_rd_en = 1'b1;
            addr_in   = addr_ff + 1'b1;
            left_in   = left_ff - 1'b1;
            if (left_ff == COUNT_BITS'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DIVGO;
         end
         ST_DIVGO: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = err_ff;
               rsp_span_in   = err_ff ? '0 : span_ff;
               rsp_mean_in   = err_ff ? '0 : div_quo[RESULT_BITS-1:0];
               rsp_max_in    = err_ff ? '0 : max_ff;
               rsp_min_in    = err_ff ? '0 : min_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff[0]  <= '0;
         count_ff[1]  <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // window datapath and response word
   always_ff @(posedge clock) begin
      ch_ff         <= ch_in;
      addr_ff       <= addr_in;
      left_ff       <= left_in;
      span_ff       <= span_in;
      eq_ff         <= eq_in;
      err_ff        <= err_in;
      sum_ff        <= sum_in;
      max_ff        <= max_in;
      min_ff        <= min_in;
      rsp_status_ff <= rsp_status_in;
      rsp_span_ff   <= rsp_span_in;
      rsp_mean_ff   <= rsp_mean_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_min_ff    <= rsp_min_in;
   end

   // starting-minimum registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_cur_ff  <= MIN_START_CURRENT_RESET;
         min_volt_ff <= MIN_START_VOLTAGE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MIN_START_CURRENT: min_cur_ff  <= SAMPLE_BITS'(csr_wr_data);
            CSR_MIN_START_VOLTAGE: min_volt_ff <= SAMPLE_BITS'(csr_wr_data);
            default: begin
            end
         endcase
      end
   end

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.status     = rsp_status_ff;
   assign rsp_port.span       = rsp_span_ff;
   assign rsp_port.mean_value = rsp_mean_ff;
   assign rsp_port.peak_max   = rsp_max_ff;
   assign rsp_port.peak_min   = rsp_min_ff;

   // fill counts never pass the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff[0] <= COUNT_BITS'(STORE_DEPTH)) && (count_ff[1] <= COUNT_BITS'(STORE_DEPTH)))
      else $error("sample count beyond store depth");

   // a window scan only reads written entries
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (COUNT_BITS'(addr_ff) < count_ff[ch_ff]))
      else $error("window read past fill count");

   // a range error carries all-zero fields
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |->
      (rsp_span_ff == '0 && rsp_mean_ff == '0 && rsp_max_ff == '0 && rsp_min_ff == '0))
      else $error("range error word with nonzero fields");

   // divider completes only while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIV))
      else $error("divider done outside divide state");

endmodule
